### src/stf_pkg.sv
// ----------------------------------------------------------------------------
// stf_pkg: shared types and constants of the scanline triangle filler
// coordinate and error widths, phase encodings, register map, request and
// result structs
// ----------------------------------------------------------------------------
package stf_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 8;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // action codes of an input request
  typedef logic [1:0] action_t;
  localparam action_t ACT_TICK      = 2'd0;
  localparam action_t ACT_START     = 2'd1;
  localparam action_t ACT_CLEAR     = 2'd2;
  localparam action_t ACT_CLEAR_ALT = 2'd3;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_V0X   = 3'd0,
    REG_V0Y   = 3'd1,
    REG_V1X   = 3'd2,
    REG_V1Y   = 3'd3,
    REG_V2X   = 3'd4,
    REG_V2Y   = 3'd5,
    REG_COLOR = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_INIT_A   = 4'd1,
    PH_INIT_B0  = 4'd2,
    PH_INIT_B1  = 4'd3,
    PH_START_A  = 4'd4,
    PH_START_B  = 4'd5,
    PH_START_H  = 4'd6,
    PH_EDGE     = 4'd7,
    PH_HLINE    = 4'd8,
    PH_DONE     = 4'd9
  } fill_phase_t;

  typedef enum logic [1:0] {
    W_IDLE  = 2'd0,
    W_INIT0 = 2'd1,
    W_INIT1 = 2'd2,
    W_DRAW  = 2'd3
  } walk_phase_t;

  typedef struct packed {
    logic clr;
    logic go;
    logic en;
  } walk_ctl_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } edge_t;

  typedef struct packed {
    action_t action;
    logic    out_ready;
  } stf_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    color_t pixel_color;
    logic   busy_res;
    logic   done_res;
  } stf_out_t;

endpackage

### src/stf_edge_walker.sv
// ----------------------------------------------------------------------------
// stf_edge_walker: downward-only bresenham edge stepper
// moves one step per enabled request, x left or right, y only down
// ----------------------------------------------------------------------------
module stf_edge_walker import stf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  walk_ctl_t ctl,
  input  edge_t     ends,
  output coord_t    pos_x,
  output coord_t    pos_y,
  output logic      busy
);

  typedef logic signed [ERR_BITS:0] e2_t;

  walk_phase_t ph_r, ph_nxt;
  logic        right_r, right_nxt;
  err_t        err_r, err_nxt;
  delta_t      dx_r, dx_nxt;
  delta_t      dy_r, dy_nxt;
  coord_t      x_r, x_nxt;
  coord_t      y_r, y_nxt;

  e2_t    e2;
  logic   mx;
  logic   my;
  coord_t x_step;

  assign e2     = $signed({err_r, 1'b0});
  assign mx     = e2 >= e2_t'(dy_r);
  assign my     = e2 <= e2_t'(dx_r);
  assign x_step = right_r ? x_r + coord_t'(1) : x_r - coord_t'(1);

  always_comb begin
    ph_nxt    = ph_r;
    right_nxt = right_r;
    err_nxt   = err_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    unique case (ph_r)
      W_DRAW: begin
        if (ctl.en) begin
          if (x_r == ends.x1 && y_r == ends.y1) begin
            ph_nxt = W_IDLE;
          end else if (mx && my) begin
            x_nxt   = x_step;
            y_nxt   = y_r + coord_t'(1);
            err_nxt = err_r + err_t'(dy_r) + err_t'(dx_r);
          end else if (mx) begin
            x_nxt   = x_step;
            err_nxt = err_r + err_t'(dy_r);
          end else if (my) begin
            y_nxt   = y_r + coord_t'(1);
            err_nxt = err_r + err_t'(dx_r);
          end
        end
      end
      W_INIT0: begin
        ph_nxt = W_INIT1;
        dx_nxt = right_r ? delta_t'(ends.x1) - delta_t'(ends.x0)
                         : delta_t'(ends.x0) - delta_t'(ends.x1);
        dy_nxt = delta_t'(ends.y0) - delta_t'(ends.y1);
      end
      W_INIT1: begin
        ph_nxt  = W_DRAW;
        err_nxt = err_t'(dx_r) + err_t'(dy_r);
        x_nxt   = ends.x0;
        y_nxt   = ends.y0;
      end
      default: begin
        if (ctl.go) begin
          ph_nxt    = W_INIT0;
          right_nxt = ends.x0 < ends.x1;
        end
      end
    endcase
    if (ctl.clr) begin
      ph_nxt = W_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= W_IDLE;
      right_r <= 1'b0;
      err_r   <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end else if (step) begin
      ph_r    <= ph_nxt;
      right_r <= right_nxt;
      err_r   <= err_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  assign pos_x = x_r;
  assign pos_y = y_r;
  assign busy  = ph_r != W_IDLE;

endmodule

### src/scanline_triangle_filler_top.sv
// ----------------------------------------------------------------------------
// scanline_triangle_filler_top: filled-triangle rasterizer, one tick per request
// sorts three vertices by y, walks the long and the two short edges and emits
// each row as a left-to-right span of pixels
// ----------------------------------------------------------------------------
// Each input request is one tick of the rasterizer and produces exactly one
// result in the next cycle, through an output register; a new request is taken
// every cycle as long as that register is empty or being drained, so the
// sustained rate is one request per clock. All state touched by a request
// (fill sequencer, both edge walkers, span stepper) updates
// in the accepting cycle; the longest path is the edge walker error update
// (a 15-bit compare feeding a 14-bit add). The vertex and color registers sit
// on an APB-style port at byte addresses 0..24; vertices are latched and
// sorted when a start request arrives in idle, the color is applied live to
// each emitted pixel. A start while busy is ignored, a clear (action 2 or 3)
// returns every sequencer to idle.
// ----------------------------------------------------------------------------
module scanline_triangle_filler_top import stf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stf_in_t              in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output stf_out_t             out_data,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  // --------------------------------------------------------------------------
  // register file
  // --------------------------------------------------------------------------
  coord_t   v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  color_t   color_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0x_r   <= '0;
      v0y_r   <= '0;
      v1x_r   <= '0;
      v1y_r   <= '0;
      v2x_r   <= '0;
      v2y_r   <= '0;
      color_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_V0X:   v0x_r   <= pwdata[COORD_BITS-1:0];
        REG_V0Y:   v0y_r   <= pwdata[COORD_BITS-1:0];
        REG_V1X:   v1x_r   <= pwdata[COORD_BITS-1:0];
        REG_V1Y:   v1y_r   <= pwdata[COORD_BITS-1:0];
        REG_V2X:   v2x_r   <= pwdata[COORD_BITS-1:0];
        REG_V2Y:   v2y_r   <= pwdata[COORD_BITS-1:0];
        REG_COLOR: color_r <= pwdata[COLOR_BITS-1:0];
        default: ;  // write past the register map is dropped
      endcase
    end
  end

  // read back zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_V0X:   prdata = DATA_BITS'(unsigned'(v0x_r));
      REG_V0Y:   prdata = DATA_BITS'(unsigned'(v0y_r));
      REG_V1X:   prdata = DATA_BITS'(unsigned'(v1x_r));
      REG_V1Y:   prdata = DATA_BITS'(unsigned'(v1y_r));
      REG_V2X:   prdata = DATA_BITS'(unsigned'(v2x_r));
      REG_V2Y:   prdata = DATA_BITS'(unsigned'(v2y_r));
      REG_COLOR: prdata = DATA_BITS'(color_r);
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // request handshake: output register parts the two sides
  // --------------------------------------------------------------------------
  logic  acc;
  logic  go;
  logic  clr;
  logic  rdy;

  assign in_stall = out_valid && out_stall;
  assign acc      = in_valid && !in_stall;
  assign go       = in_data.action == ACT_START;
  assign clr      = in_data.action inside {ACT_CLEAR, ACT_CLEAR_ALT};
  assign rdy      = in_data.out_ready;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  fill_phase_t phase_r, phase_nxt;
  coord_t      sx_r [3];
  coord_t      sy_r [3];
  coord_t      sx_nxt [3];
  coord_t      sy_nxt [3];
  edge_t       ea_r, ea_nxt;         // long edge endpoints
  edge_t       eb_r, eb_nxt;         // short edge endpoints
  coord_t      prev_y_r, prev_y_nxt; // current row
  coord_t      prev_xa_r, prev_xa_nxt;
  coord_t      prev_xb_r, prev_xb_nxt;
  coord_t      x0h_r, x0h_nxt;
  coord_t      x1h_r, x1h_nxt;
  coord_t      xh_r, xh_nxt;
  logic        span_on_r, span_on_nxt;
  logic        second_b_r, second_b_nxt;
  logic        done_r, done_nxt;

  coord_t      wa_x, wa_y, wb_x, wb_y;
  logic        wa_busy, wb_busy;
  walk_ctl_t   wa_ctl, wb_ctl;

  // both walkers have left the current row or are idle
  logic        row_walked;
  assign row_walked = (wa_y != prev_y_r || !wa_busy) && (wb_y != prev_y_r || !wb_busy);

  // --------------------------------------------------------------------------
  // fill sequencer: next phase
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_INIT_A:  phase_nxt = PH_INIT_B0;
      PH_INIT_B0: phase_nxt = PH_START_A;
      PH_INIT_B1: phase_nxt = PH_START_B;
      PH_START_A: phase_nxt = PH_START_B;
      PH_START_B: phase_nxt = PH_EDGE;
      PH_EDGE: begin
        if (row_walked) begin
          phase_nxt = PH_START_H;
        end
      end
      PH_START_H: phase_nxt = PH_HLINE;
      PH_HLINE: begin
        if (!span_on_r) begin
          if (!wb_busy) begin
            // long edge unfinished after the first short edge: take the second
            phase_nxt = (wa_busy && !second_b_r) ? PH_INIT_B1 : PH_DONE;
          end else begin
            phase_nxt = PH_EDGE;
          end
        end
      end
      PH_DONE: phase_nxt = PH_IDLE;
      default: phase_nxt = go ? PH_INIT_A : PH_IDLE;
    endcase
    if (clr) begin
      phase_nxt = PH_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // fill sequencer: datapath loads
  // --------------------------------------------------------------------------
  always_comb begin
    coord_t tx;
    coord_t ty;
    coord_t vx [3];
    coord_t vy [3];

    // three compare-and-swap stages on y: 0/2, 0/1, 1/2
    tx = '0;
    ty = '0;
    vx[0] = v0x_r; vy[0] = v0y_r;
    vx[1] = v1x_r; vy[1] = v1y_r;
    vx[2] = v2x_r; vy[2] = v2y_r;
    if (vy[0] > vy[2]) begin
      tx = vx[0]; vx[0] = vx[2]; vx[2] = tx;
      ty = vy[0]; vy[0] = vy[2]; vy[2] = ty;
    end
    if (vy[0] > vy[1]) begin
      tx = vx[0]; vx[0] = vx[1]; vx[1] = tx;
      ty = vy[0]; vy[0] = vy[1]; vy[1] = ty;
    end
    if (vy[1] > vy[2]) begin
      tx = vx[1]; vx[1] = vx[2]; vx[2] = tx;
      ty = vy[1]; vy[1] = vy[2]; vy[2] = ty;
    end

    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    ea_nxt       = ea_r;
    eb_nxt       = eb_r;
    prev_y_nxt   = prev_y_r;
    prev_xa_nxt  = prev_xa_r;
    prev_xb_nxt  = prev_xb_r;
    x0h_nxt      = x0h_r;
    x1h_nxt      = x1h_r;
    second_b_nxt = second_b_r;
    done_nxt     = done_r;

    unique case (phase_r)
      PH_INIT_A: begin
        ea_nxt      = '{x0: sx_r[0], y0: sy_r[0], x1: sx_r[2], y1: sy_r[2]};
        prev_xa_nxt = sx_r[0];
        prev_xb_nxt = sx_r[0];
      end
      PH_INIT_B0: begin
        second_b_nxt = 1'b0;
        eb_nxt       = '{x0: sx_r[0], y0: sy_r[0], x1: sx_r[1], y1: sy_r[1]};
        prev_y_nxt   = sy_r[0];
      end
      PH_INIT_B1: begin
        second_b_nxt = 1'b1;
        eb_nxt       = '{x0: sx_r[1], y0: sy_r[1], x1: sx_r[2], y1: sy_r[2]};
        prev_y_nxt   = sy_r[1];
      end
      PH_START_A, PH_START_B, PH_START_H: ;
      PH_EDGE: begin
        if (row_walked) begin
          x0h_nxt = (prev_xa_r > prev_xb_r) ? prev_xb_r : prev_xa_r;
          x1h_nxt = (prev_xa_r > prev_xb_r) ? prev_xa_r : prev_xb_r;
        end
      end
      PH_HLINE: begin
        if (!span_on_r) begin
          prev_y_nxt  = wb_y;
          prev_xa_nxt = wa_x;
          prev_xb_nxt = wb_x;
        end
      end
      PH_DONE: done_nxt = 1'b1;
      default: begin
        if (go) begin
          sx_nxt = vx;
          sy_nxt = vy;
        end
        done_nxt = 1'b0;
      end
    endcase
    if (clr) begin
      done_nxt     = 1'b0;
      second_b_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // edge walkers see the updated phase, row and endpoints
  // --------------------------------------------------------------------------
  always_comb begin
    wa_ctl.clr = clr;
    wa_ctl.go  = phase_nxt == PH_START_A;
    wa_ctl.en  = phase_nxt == PH_EDGE && wa_y == prev_y_nxt;
    wb_ctl.clr = clr;
    wb_ctl.go  = phase_nxt == PH_START_B;
    wb_ctl.en  = phase_nxt == PH_EDGE && wb_y == prev_y_nxt;
  end

  stf_edge_walker u_walk_a (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (acc),
    .ctl   (wa_ctl),
    .ends  (ea_nxt),
    .pos_x (wa_x),
    .pos_y (wa_y),
    .busy  (wa_busy)
  );

  stf_edge_walker u_walk_b (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (acc),
    .ctl   (wb_ctl),
    .ends  (eb_nxt),
    .pos_x (wb_x),
    .pos_y (wb_y),
    .busy  (wb_busy)
  );

  // --------------------------------------------------------------------------
  // span stepper and result
  // --------------------------------------------------------------------------
  stf_out_t res;

  always_comb begin
    span_on_nxt = span_on_r;
    xh_nxt      = xh_r;
    if (span_on_r) begin
      if (rdy) begin
        if (xh_r == x1h_nxt) begin
          span_on_nxt = 1'b0;
        end else begin
          xh_nxt = xh_r + coord_t'(1);
        end
      end
    end else if (phase_nxt == PH_START_H) begin
      span_on_nxt = 1'b1;
      xh_nxt      = x0h_nxt;
    end
    if (clr) begin
      span_on_nxt = 1'b0;
    end

    res.pixel_x     = xh_nxt;
    res.pixel_y     = prev_y_nxt;
    res.pixel_valid = span_on_nxt && rdy;
    res.pixel_color = (span_on_nxt && rdy) ? color_r : '0;
    res.busy_res    = phase_nxt != PH_IDLE;
    res.done_res    = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      sx_r       <= '{default: '0};
      sy_r       <= '{default: '0};
      ea_r       <= '0;
      eb_r       <= '0;
      prev_y_r   <= '0;
      prev_xa_r  <= '0;
      prev_xb_r  <= '0;
      x0h_r      <= '0;
      x1h_r      <= '0;
      xh_r       <= '0;
      span_on_r  <= 1'b0;
      second_b_r <= 1'b0;
      done_r     <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
      ea_r       <= ea_nxt;
      eb_r       <= eb_nxt;
      prev_y_r   <= prev_y_nxt;
      prev_xa_r  <= prev_xa_nxt;
      prev_xb_r  <= prev_xb_nxt;
      x0h_r      <= x0h_nxt;
      x1h_r      <= x1h_nxt;
      xh_r       <= xh_nxt;
      span_on_r  <= span_on_nxt;
      second_b_r <= second_b_nxt;
      done_r     <= done_nxt;
    end
  end

  // output register: loaded on every accepted request, held while stalled
  logic     out_valid_r, out_valid_nxt;
  stf_out_t out_data_r;

  assign out_valid_nxt = acc ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/stf_checker.sv
// ----------------------------------------------------------------------------
// stf_checker: port-level checks of the scanline triangle filler
// request to result timing, result holding, status flag consistency
// ----------------------------------------------------------------------------
module stf_checker import stf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input stf_out_t out_data
);

  // every accepted request shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // a stalled result stays put
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // pixels are only emitted while a triangle is in progress
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pixel_valid) |-> out_data.busy_res)
    else $error("pixel emitted while not busy");

  // done pulse never overlaps busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.busy_res && out_data.done_res))
    else $error("done and busy both set");

endmodule

bind scanline_triangle_filler_top stf_checker u_stf_checker (.*);

### bench/tb_scanline_triangle_filler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scanline_triangle_filler_top: self-checking bench of the triangle filler
// each request is one rasterizer tick; a cycle-exact shadow of the filler
// predicts the pixel result of every accepted request; vertices and color
// are programmed over the register port while no request is in flight
// ----------------------------------------------------------------------------
module tb_scanline_triangle_filler_top;
  import stf_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 80;
  localparam int FILL_CAP       = 20000;
  localparam int ITEM_GOAL      = 600;
  localparam int MIN_RAND_ITEMS = 100;
  localparam int MAX_REPORTS    = 40;

  // one Bresenham edge stepper
  typedef struct packed {
    walk_phase_t ph;
    logic        right;
    logic        busy;
    err_t        err;
    delta_t      dx;
    delta_t      dy;
    coord_t      x;
    coord_t      y;
    coord_t      x0;
    coord_t      y0;
    coord_t      x1;
    coord_t      y1;
  } edge_walker_t;

  // whole filler state plus its register copy
  typedef struct packed {
    coord_t [5:0] vtx;
    color_t       color;
    fill_phase_t  phase;
    coord_t [2:0] sx;
    coord_t [2:0] sy;
    edge_walker_t wa;
    edge_walker_t wb;
    logic         span_on;
    logic         busy_h;
    coord_t       x0h;
    coord_t       x1h;
    coord_t       xh;
    coord_t       prev_y;
    coord_t       prev_xa;
    coord_t       prev_xb;
    logic         second_b;
    logic         busy_p;
    logic         done_p;
  } raster_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE} stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  stf_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  stf_out_t             out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // requests still to be offered, and pixel results still owed by the block
  stf_in_t  req_q[$];
  stf_out_t pixel_q[$];

  // live_st follows accepted requests, plan_st follows queued ones
  raster_t live_st = '0;
  raster_t plan_st = '0;

  int          n_err = 0;
  int          n_items = 0;
  int          n_cycles = 0;
  bit          req_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  scanline_triangle_filler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the filler
  // ---------------------------------------------------------------------------

  // one tick of an edge walker: moves only downwards, only when enabled
  function automatic void walker_step(inout edge_walker_t w, input logic clr, go, en);
    logic signed [ERR_BITS:0] e2;
    logic                     mx;
    logic                     my;
    e2 = {w.err, 1'b0};
    mx = e2 >= $signed(w.dy);
    my = e2 <= $signed(w.dx);
    case (w.ph)
      W_DRAW: begin
        if (en) begin
          if (w.x == w.x1 && w.y == w.y1) begin
            w.ph   = W_IDLE;
            w.busy = 1'b0;
          end else if (mx && my) begin
            w.x   = w.right ? w.x + 1'b1 : w.x - 1'b1;
            w.y   = w.y + 1'b1;
            w.err = w.err + err_t'($signed(w.dy)) + err_t'($signed(w.dx));
          end else if (mx) begin
            w.x   = w.right ? w.x + 1'b1 : w.x - 1'b1;
            w.err = w.err + err_t'($signed(w.dy));
          end else if (my) begin
            w.y   = w.y + 1'b1;
            w.err = w.err + err_t'($signed(w.dx));
          end
        end
      end
      W_INIT0: begin
        w.ph = W_INIT1;
        w.dx = w.right ? delta_t'($signed(w.x1)) - delta_t'($signed(w.x0))
                       : delta_t'($signed(w.x0)) - delta_t'($signed(w.x1));
        w.dy = delta_t'($signed(w.y0)) - delta_t'($signed(w.y1));
      end
      W_INIT1: begin
        w.ph  = W_DRAW;
        w.err = err_t'($signed(w.dx)) + err_t'($signed(w.dy));
        w.x   = w.x0;
        w.y   = w.y0;
      end
      default: begin
        if (go) begin
          w.ph    = W_INIT0;
          w.right = $signed(w.x0) < $signed(w.x1);
          w.busy  = 1'b1;
        end
      end
    endcase
    if (clr) begin
      w.ph   = W_IDLE;
      w.busy = 1'b0;
    end
  endfunction

  function automatic void sort_pair(inout coord_t ax, ay, bx, by);
    coord_t t;
    if ($signed(ay) > $signed(by)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
  endfunction

  // one rasterizer tick, returns the pixel result it causes
  function automatic stf_out_t raster_tick(inout raster_t s, input stf_in_t req);
    logic     go;
    logic     clr;
    logic     rdy;
    logic     pix;
    logic     en_a;
    logic     en_b;
    coord_t   c0x, c0y, c1x, c1y, c2x, c2y;
    stf_out_t r;
    go  = req.action == ACT_START;
    clr = req.action[1];
    rdy = req.out_ready;
    case (s.phase)
      PH_INIT_A: begin
        s.phase   = PH_INIT_B0;
        s.wa.x0   = s.sx[0];
        s.wa.y0   = s.sy[0];
        s.wa.x1   = s.sx[2];
        s.wa.y1   = s.sy[2];
        s.prev_xa = s.sx[0];
        s.prev_xb = s.sx[0];
      end
      PH_INIT_B0: begin
        s.phase    = PH_START_A;
        s.second_b = 1'b0;
        s.wb.x0    = s.sx[0];
        s.wb.y0    = s.sy[0];
        s.wb.x1    = s.sx[1];
        s.wb.y1    = s.sy[1];
        s.prev_y   = s.sy[0];
      end
      PH_INIT_B1: begin
        s.phase    = PH_START_B;
        s.second_b = 1'b1;
        s.wb.x0    = s.sx[1];
        s.wb.y0    = s.sy[1];
        s.wb.x1    = s.sx[2];
        s.wb.y1    = s.sy[2];
        s.prev_y   = s.sy[1];
      end
      PH_START_A: s.phase = PH_START_B;
      PH_START_B: s.phase = PH_EDGE;
      PH_EDGE: begin
        if ((s.wa.y != s.prev_y || !s.wa.busy) && (s.wb.y != s.prev_y || !s.wb.busy)) begin
          s.phase = PH_START_H;
          if ($signed(s.prev_xa) > $signed(s.prev_xb)) begin
            s.x0h = s.prev_xb;
            s.x1h = s.prev_xa;
          end else begin
            s.x0h = s.prev_xa;
            s.x1h = s.prev_xb;
          end
        end
      end
      PH_START_H: s.phase = PH_HLINE;
      PH_HLINE: begin
        if (!s.busy_h) begin
          s.prev_y  = s.wb.y;
          s.prev_xa = s.wa.x;
          s.prev_xb = s.wb.x;
          if (!s.wb.busy) s.phase = (s.wa.busy && !s.second_b) ? PH_INIT_B1 : PH_DONE;
          else s.phase = PH_EDGE;
        end
      end
      PH_DONE: begin
        s.phase  = PH_IDLE;
        s.done_p = 1'b1;
        s.busy_p = 1'b0;
      end
      default: begin
        s.phase = PH_IDLE;
        if (go) begin
          c0x = s.vtx[REG_V0X]; c0y = s.vtx[REG_V0Y];
          c1x = s.vtx[REG_V1X]; c1y = s.vtx[REG_V1Y];
          c2x = s.vtx[REG_V2X]; c2y = s.vtx[REG_V2Y];
          sort_pair(c0x, c0y, c2x, c2y);
          sort_pair(c0x, c0y, c1x, c1y);
          sort_pair(c1x, c1y, c2x, c2y);
          s.sx[0] = c0x; s.sx[1] = c1x; s.sx[2] = c2x;
          s.sy[0] = c0y; s.sy[1] = c1y; s.sy[2] = c2y;
          s.phase  = PH_INIT_A;
          s.busy_p = 1'b1;
        end
        s.done_p = 1'b0;
      end
    endcase
    if (clr) begin
      s.phase    = PH_IDLE;
      s.busy_p   = 1'b0;
      s.done_p   = 1'b0;
      s.second_b = 1'b0;
    end
    en_a = s.phase == PH_EDGE && s.wa.y == s.prev_y;
    en_b = s.phase == PH_EDGE && s.wb.y == s.prev_y;
    walker_step(s.wa, clr, s.phase == PH_START_A, en_a);
    walker_step(s.wb, clr, s.phase == PH_START_B, en_b);
    if (s.span_on) begin
      if (rdy) begin
        if (s.xh == s.x1h) begin
          s.span_on = 1'b0;
          s.busy_h  = 1'b0;
        end else begin
          s.xh = s.xh + 1'b1;
        end
      end
    end else if (s.phase == PH_START_H) begin
      s.span_on = 1'b1;
      s.xh      = s.x0h;
      s.busy_h  = 1'b1;
    end
    if (clr) begin
      s.span_on = 1'b0;
      s.busy_h  = 1'b0;
    end
    pix           = s.span_on && rdy;
    r.pixel_x     = s.xh;
    r.pixel_y     = s.prev_y;
    r.pixel_valid = pix;
    r.pixel_color = pix ? s.color : '0;
    r.busy_res    = s.busy_p;
    r.done_res    = s.done_p;
    return r;
  endfunction

  function automatic void cfg_store(inout raster_t s, input reg_idx_t idx,
                                    input logic [DATA_BITS-1:0] v);
    if (idx == REG_COLOR) s.color = v[COLOR_BITS-1:0];
    else s.vtx[idx] = v[COORD_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // request planning: every queued request also advances plan_st, so the
  // planner knows when the triangle in progress has finished
  // ---------------------------------------------------------------------------

  task automatic push_req(action_t a, logic rdy);
    stf_in_t r;
    r.action    = a;
    r.out_ready = rdy;
    req_q.push_back(r);
    void'(raster_tick(plan_st, r));
    n_items++;
  endtask

  // start (optionally) and tick a triangle until it is done, aborted or capped
  task automatic fill_triangle(bit with_start, int tick_cap, int abort_at,
                               action_t abort_act, int noise_pct);
    int      k;
    action_t a;
    if (with_start) push_req(ACT_START, 1'($urandom));
    k = 0;
    while (plan_st.busy_p && k < tick_cap) begin
      if (k == abort_at) a = abort_act;
      else if ($urandom_range(0, 99) < noise_pct) a = ACT_START;   // ignored while busy
      else a = ACT_TICK;
      push_req(a, $urandom_range(0, 3) != 0);
      k++;
    end
    // a few idle ticks after the end, now and then a clear while idle
    if (!plan_st.busy_p) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: a = ACT_CLEAR;
          1: a = ACT_CLEAR_ALT;
          default: a = ACT_TICK;
        endcase
        push_req(a, 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // register port: setup then access cycle; junk above the field width
  // ---------------------------------------------------------------------------

  task automatic reg_write(reg_idx_t idx, logic [DATA_BITS-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_store(live_st, idx, val);
    cfg_store(plan_st, idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_triangle(int ax, ay, bx, by, cx, cy, int col);
    reg_write(REG_V0X, {20'($urandom), coord_t'(ax)});
    reg_write(REG_V0Y, {20'($urandom), coord_t'(ay)});
    reg_write(REG_V1X, {20'($urandom), coord_t'(bx)});
    reg_write(REG_V1Y, {20'($urandom), coord_t'(by)});
    reg_write(REG_V2X, {20'($urandom), coord_t'(cx)});
    reg_write(REG_V2Y, {20'($urandom), coord_t'(cy)});
    reg_write(REG_COLOR, {24'($urandom), color_t'(col)});
  endtask

  // wait until every queued request has come back, plus the output latency
  task automatic drain();
    while (req_q.size() != 0 || pixel_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int rand_goal;
    int sz;
    int bx;
    int by;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset vertices: a single point at the origin
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // coincident vertices, full color
    load_triangle(5, -3, 5, -3, 5, -3, 8'hFF);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // flat top, color zero
    load_triangle(0, 0, 6, 0, 3, 4, 8'h00);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // flat bottom, vertices listed bottom first
    load_triangle(6, 4, 3, 0, 0, 4, 8'h81);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // vertical line
    load_triangle(7, 6, 7, 1, 7, 3, 8'h3C);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // hugging the positive corner
    load_triangle(2047, 2044, 2040, 2047, 2045, 2040, 8'h5A);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // hugging the negative corner
    load_triangle(-2048, -2048, -2041, -2045, -2046, -2041, 8'hA5);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // single row on the last line
    load_triangle(-2048, 2047, -2040, 2047, -2044, 2047, 8'hC3);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // vertex and color rewrite in the middle of a fill
    load_triangle(0, 0, 5, 5, -4, 8, 8'h11);
    fill_triangle(1'b1, 12, -1, ACT_CLEAR, 0);
    drain();
    load_triangle(100, -50, -100, 30, 9, 9, 8'hEE);
    fill_triangle(1'b0, FILL_CAP, -1, ACT_CLEAR, 0);
    drain();
    // starts while busy, then both clear codes mid fill
    load_triangle(-3, 2, 4, -5, 1, 6, 8'h7E);
    fill_triangle(1'b1, FILL_CAP, -1, ACT_CLEAR, 25);
    fill_triangle(1'b1, FILL_CAP, 9, ACT_CLEAR, 0);
    fill_triangle(1'b1, FILL_CAP, 20, ACT_CLEAR_ALT, 0);
    drain();

    // random triangles up to the item goal but at least MIN_RAND_ITEMS more,
    // mostly small; sometimes no reprogramming in between
    rand_goal = (n_items + MIN_RAND_ITEMS > ITEM_GOAL) ? n_items + MIN_RAND_ITEMS
                                                       : ITEM_GOAL;
    while (n_items < rand_goal) begin
      if ($urandom_range(0, 2) != 0) begin
        drain();
        sz = ($urandom_range(0, 7) == 0) ? 10 : $urandom_range(0, 4);
        bx = int'($urandom_range(0, 4095 - sz)) - 2048;
        by = int'($urandom_range(0, 4095 - sz)) - 2048;
        load_triangle(bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                      bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                      bx + $urandom_range(0, sz), by + $urandom_range(0, sz),
                      $urandom_range(0, 255));
      end
      fill_triangle(1'b1, FILL_CAP,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : -1,
                    $urandom_range(0, 1) ? ACT_CLEAR : ACT_CLEAR_ALT,
                    $urandom_range(0, 1) ? 0 : 5);
    end

    drain();
    repeat (4) @(posedge clk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps; a request
  // stays on the bus unchanged until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    logic    nxt_valid;
    stf_in_t nxt_data;
    nxt_valid = 1'b0;
    nxt_data  = in_data;
    if (req_taken) void'(req_q.pop_front());
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (in_valid && !req_taken) begin
      // still waiting on the block
      nxt_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (req_q.size() > 0) begin
      nxt_valid = 1'b1;
      nxt_data  = req_q[0];
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        // half the bursts run straight into the next one
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // result side: one long hold-off once a big backlog is queued, otherwise
  // windows of no stall, random stall or toggling stall
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (!rst_n) begin
      nxt_stall = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (!hold_done && req_q.size() >= 30) begin
      // let the block fill up and push back on the request side
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
      nxt_stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(4, 60);
      end
      mode_left--;
      case (stall_mode)
        STALL_RANDOM: nxt_stall = $urandom_range(0, 2) == 0;
        STALL_TOGGLE: nxt_stall = !out_stall;
        default:      nxt_stall = 1'b0;
      endcase
    end
    out_stall <= nxt_stall;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    stf_out_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("%0t: result with no request pending, got %h", $time, out_data);
        end else begin
          want = pixel_q.pop_front();
          if (out_data !== want) begin
            n_err++;
            if (n_err <= MAX_REPORTS) begin
              $display("%0t: expected x=%0d y=%0d valid=%b color=%h busy=%b done=%b",
                       $time, $signed(want.pixel_x), $signed(want.pixel_y),
                       want.pixel_valid, want.pixel_color, want.busy_res, want.done_res);
              $display("%0t:      got x=%0d y=%0d valid=%b color=%h busy=%b done=%b",
                       $time, $signed(out_data.pixel_x), $signed(out_data.pixel_y),
                       out_data.pixel_valid, out_data.pixel_color, out_data.busy_res,
                       out_data.done_res);
            end
          end
        end
      end
      // requests are one tick each; the result comes back in a later cycle
      if (in_valid && !in_stall) begin
        pixel_q.push_back(raster_tick(live_st, in_data));
        req_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

### files.f
src/stf_pkg.sv
src/stf_edge_walker.sv
src/scanline_triangle_filler_top.sv
src/stf_checker.sv
bench/tb_scanline_triangle_filler_top.sv
